[rtl/ifst_pkg.sv]
package ifst_pkg;

   localparam int NUM_SLOTS_DEFAULT = 64;

   // field widths
   localparam int TS_W   = 63;
   localparam int AGE_W  = 44;

   localparam int NS_PER_MS = 1000000;
   localparam int DIV_W     = $clog2(NS_PER_MS);

   // operation codes
   localparam logic [1:0] OP_BEGIN = 2'd0;
   localparam logic [1:0] OP_END   = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

endpackage

[rtl/ifst_ram.sv]
module ifst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ifst_div.sv]
module ifst_div import ifst_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [TS_W-1:0]  dividend,
   output logic             done,
   output logic [AGE_W-1:0] quotient
);

   // 10^6 = 2^6 * 15625: drop the power of two, then multiply by the reciprocal of 15625
   // rounded up at 2^-71, which is exact for any 57-bit argument
   localparam int POW2_SHIFT  = 6;
   localparam int ARG_W       = TS_W - POW2_SHIFT;
   localparam int RECIP_W     = 58;
   localparam int RECIP_SHIFT = 71;
   localparam int ACC_W       = ARG_W + RECIP_W;
   localparam int LIMB_W      = 32;
   localparam int PROD_W      = 2 * LIMB_W;
   localparam logic [PROD_W-1:0] RECIP     = 64'd151115727451828647;
   localparam logic [1:0]        LAST_STEP = 2'd3;

   logic [ARG_W-1:0]  arg_ff, arg_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [1:0]        step_ff, step_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [LIMB_W-1:0] arg_limb;
   logic [LIMB_W-1:0] recip_limb;
   logic [PROD_W-1:0] prod;
   logic [ACC_W-1:0]  term;

   // one 32x32 partial product a cycle: low x low, low x high, high x low, high x high
   assign arg_limb   = step_ff[1] ? LIMB_W'(arg_ff[ARG_W-1:LIMB_W]) : arg_ff[LIMB_W-1:0];
   assign recip_limb = step_ff[0] ? RECIP[PROD_W-1:LIMB_W] : RECIP[LIMB_W-1:0];
   assign prod       = PROD_W'(arg_limb) * PROD_W'(recip_limb);

   always_comb begin
      case (step_ff)
         2'd0:      term = ACC_W'(prod);
         LAST_STEP: term = ACC_W'(prod) << PROD_W;
         default:   term = ACC_W'(prod) << LIMB_W;
      endcase
   end

   always_comb begin
      arg_in  = arg_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         arg_in  = dividend[TS_W-1:POW2_SHIFT];
         acc_in  = '0;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         acc_in  = acc_ff + term;
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      arg_ff  <= arg_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
   end

   assign done     = done_ff;
   assign quotient = acc_ff[RECIP_SHIFT +: AGE_W];

endmodule

[rtl/in_flight_slot_tracker_core.sv]
// Tracks up to NUM_SLOTS in-flight requests by start timestamp. A begin beat claims the first free
// slot from a rotating hint, an end beat frees a slot, a query beat changes nothing; every beat
// returns one result with the busy count and the age in ms of the oldest busy slot. After reset
// the slot memory is cleared with req_ready low. Each beat then makes one full pass through
// the slot memory at one read a cycle (free search, count and minimum together), the claim write,
// and a divide of the age by 10^6 as a reciprocal multiply, one 32x32 partial product a cycle.
// A new beat is taken the cycle after the result is registered, while that result may still
// wait on rsp_ready.
module in_flight_slot_tracker_core import ifst_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_operation,
   input  logic [TS_W-1:0]  req_timestamp_ns,
   input  logic [5:0]       req_slot_index,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [5:0]       rsp_granted_slot,
   output logic             rsp_slot_granted,
   output logic [6:0]       rsp_busy_count,
   output logic [AGE_W-1:0] rsp_oldest_age_ms
);

   localparam int IDX_W = $clog2(NUM_SLOTS);
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_SLOTS - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_SLOTS);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SLOTS - 1);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_COMMIT, S_AGE, S_DIV, S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   tag_ff, tag_in;
   logic [IDX_W-1:0]   hint_ff, hint_in;
   logic [1:0]         op_ff, op_in;
   logic [TS_W-1:0]    now_ff, now_in;
   logic [CNT_W-1:0]   busy_ff, busy_in;
   logic [TS_W-1:0]    min_ff, min_in;
   logic               hi_found_ff, hi_found_in;
   logic [IDX_W-1:0]   hi_idx_ff, hi_idx_in;
   logic               lo_found_ff, lo_found_in;
   logic [IDX_W-1:0]   lo_idx_ff, lo_idx_in;
   logic               grant_ok_ff, grant_ok_in;
   logic [IDX_W-1:0]   grant_idx_ff, grant_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [5:0]         rsp_slot_ff, rsp_slot_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [6:0]         rsp_busy_ff, rsp_busy_in;
   logic [AGE_W-1:0]   rsp_age_ff, rsp_age_in;

   logic               accept;
   logic               slot_ok;
   logic               found;
   logic [IDX_W-1:0]   grant_sel;
   logic [TS_W-1:0]    stamp;
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [TS_W-1:0]    ram_wr_data;
   logic               ram_rd_en;
   logic [TS_W-1:0]    ram_rd_data;
   logic               div_start;
   logic [TS_W-1:0]    div_dividend;
   logic               div_done;
   logic [AGE_W-1:0]   div_quotient;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_ok   = ({26'd0, req_slot_index} < 32'(NUM_SLOTS));
   assign found     = hi_found_ff || lo_found_ff;
   assign grant_sel = hi_found_ff ? hi_idx_ff : lo_idx_ff;
   assign stamp     = (now_ff == '0) ? TS_W'(1) : now_ff;

   ifst_ram #(
      .WIDTH (TS_W),
      .DEPTH (NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   ifst_div u_age_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // memory port control
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cnt_ff[IDX_W-1:0];
      ram_wr_data = '0;
      case (state_ff)
         S_CLEAR: begin
            ram_wr_en = 1'b1;
         end
         S_IDLE: begin
            ram_wr_en   = accept && (req_operation == OP_END) && slot_ok;
            ram_wr_addr = IDX_W'(req_slot_index);
         end
         S_COMMIT: begin
            ram_wr_en   = (op_ff == OP_BEGIN) && found;
            ram_wr_addr = grant_sel;
            ram_wr_data = stamp;
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   assign ram_rd_en    = (state_ff == S_SCAN) && (cnt_ff != CNT_FULL);
   assign div_start    = (state_ff == S_AGE);
   assign div_dividend = ((min_ff != '0) && (now_ff > min_ff)) ? (now_ff - min_ff) : '0;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      tag_in       = tag_ff;
      hint_in      = hint_ff;
      op_in        = op_ff;
      now_in       = now_ff;
      busy_in      = busy_ff;
      min_in       = min_ff;
      hi_found_in  = hi_found_ff;
      hi_idx_in    = hi_idx_ff;
      lo_found_in  = lo_found_ff;
      lo_idx_in    = lo_idx_ff;
      grant_ok_in  = grant_ok_ff;
      grant_idx_in = grant_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_busy_in  = rsp_busy_ff;
      rsp_age_in   = rsp_age_ff;
      case (state_ff)
         S_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in       = req_operation;
               now_in      = req_timestamp_ns;
               cnt_in      = '0;
               busy_in     = '0;
               min_in      = '0;
               hi_found_in = 1'b0;
               lo_found_in = 1'b0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            // read data arrives the cycle after its address; tag_ff names the entry arriving
            tag_in = cnt_ff[IDX_W-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff != '0) begin
               if (ram_rd_data != '0) begin
                  busy_in = busy_ff + 1'b1;
                  if ((min_ff == '0) || (ram_rd_data < min_ff)) begin
                     min_in = ram_rd_data;
                  end
               end else begin
                  if (!hi_found_ff && (tag_ff >= hint_ff)) begin
                     hi_found_in = 1'b1;
                     hi_idx_in   = tag_ff;
                  end
                  if (!lo_found_ff) begin
                     lo_found_in = 1'b1;
                     lo_idx_in   = tag_ff;
                  end
               end
            end
            if (cnt_ff == CNT_FULL) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            grant_ok_in  = 1'b0;
            grant_idx_in = '0;
            if (op_ff == OP_BEGIN) begin
               hint_in = (hint_ff == IDX_LAST) ? '0 : hint_ff + 1'b1;
               if (found) begin
                  grant_ok_in  = 1'b1;
                  grant_idx_in = grant_sel;
                  busy_in      = busy_ff + 1'b1;
                  if ((min_ff == '0) || (stamp < min_ff)) begin
                     min_in = stamp;
                  end
               end
            end
            state_in = S_AGE;
         end
         S_AGE: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = 6'(grant_idx_ff);
               rsp_ok_in    = grant_ok_ff;
               rsp_busy_in  = 7'(busy_ff);
               rsp_age_in   = div_quotient;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         hint_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         busy_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         hint_ff      <= hint_in;
         rsp_valid_ff <= rsp_valid_in;
         busy_ff      <= busy_in;
      end
      tag_ff       <= tag_in;
      op_ff        <= op_in;
      now_ff       <= now_in;
      min_ff       <= min_in;
      hi_found_ff  <= hi_found_in;
      hi_idx_ff    <= hi_idx_in;
      lo_found_ff  <= lo_found_in;
      lo_idx_ff    <= lo_idx_in;
      grant_ok_ff  <= grant_ok_in;
      grant_idx_ff <= grant_idx_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_busy_ff  <= rsp_busy_in;
      rsp_age_ff   <= rsp_age_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_slot  = rsp_slot_ff;
   assign rsp_slot_granted  = rsp_ok_ff;
   assign rsp_busy_count    = rsp_busy_ff;
   assign rsp_oldest_age_ms = rsp_age_ff;

`ifndef SYNTH
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> !ram_rd_en)
      else $error("slot memory written and read in the same cycle");

   a_busy_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (busy_ff <= CNT_FULL))
      else $error("busy count beyond table size");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished while not awaited");

   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_SCAN) && (cnt_ff == '0) && (busy_ff == '0))
      else $error("scan did not start cleanly after accept");
`endif

endmodule

[tb/sv/in_flight_slot_tracker_core_tb.sv]
`timescale 1ns / 1ps

module in_flight_slot_tracker_core_tb import ifst_pkg::*; ();

   localparam int NUM_SLOTS    = NUM_SLOTS_DEFAULT;
   localparam int CYCLE_LIMIT  = 3000000;
   localparam int LONG_HOLD    = 1500;
   localparam int RANDOM_BEATS = 1070;

   // code 3 is decoded as a query
   localparam logic [1:0] OP_SPARE = 2'd3;

   localparam logic [TS_W-1:0] TS_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

   localparam int RX_OPEN     = 0;
   localparam int RX_RANDOM   = 1;
   localparam int RX_PERIODIC = 2;

   localparam int MIX_FILL  = 0;
   localparam int MIX_DRAIN = 1;
   localparam int MIX_BLEND = 2;

   typedef struct packed {
      logic [5:0]       granted_slot;
      logic             slot_granted;
      logic [6:0]       busy_count;
      logic [AGE_W-1:0] oldest_age_ms;
   } slot_rsp_type;

   typedef struct {
      logic [1:0]      op;
      logic [TS_W-1:0] ts;
      logic [5:0]      idx;
      int              reps;
      logic [TS_W-1:0] step;
      bit              typed;
      slot_rsp_type    want;
   } script_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [1:0]       req_operation = OP_QUERY;
   logic [TS_W-1:0]  req_timestamp_ns = '0;
   logic [5:0]       req_slot_index = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [5:0]       rsp_granted_slot;
   logic             rsp_slot_granted;
   logic [6:0]       rsp_busy_count;
   logic [AGE_W-1:0] rsp_oldest_age_ms;

   // shadow of the slot table
   logic [63:0] slot_stamp [NUM_SLOTS];
   int          scan_hint;
   int          peak_mark;

   slot_rsp_type pending_rsp [$];
   int        mismatches = 0;
   int        cycle_count = 0;
   int        burst_left = 0;
   bit        want_long_hold = 1'b0;
   bit        long_hold_done = 1'b0;
   int        hold_count = 0;
   int        rx_mode = RX_OPEN;
   int        rx_left = 0;

   in_flight_slot_tracker_core #(.NUM_SLOTS(NUM_SLOTS)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_timestamp_ns  (req_timestamp_ns),
      .req_slot_index    (req_slot_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_granted_slot  (rsp_granted_slot),
      .rsp_slot_granted  (rsp_slot_granted),
      .rsp_busy_count    (rsp_busy_count),
      .rsp_oldest_age_ms (rsp_oldest_age_ms)
   );

   always #1 clock = ~clock;

   function automatic slot_rsp_type track_beat(logic [1:0] op, logic [TS_W-1:0] ts,
                                               logic [5:0] idx);
      slot_rsp_type r;
      logic [63:0] now;
      logic [63:0] oldest;
      int first;
      int pick;
      int span;
      int n;
      now    = {1'b0, ts};
      r      = '0;
      oldest = '0;
      pick   = -1;
      n      = 0;
      if (op == OP_BEGIN) begin
         first     = scan_hint;
         scan_hint = (first + 1) % NUM_SLOTS;
         for (int i = 0; i < NUM_SLOTS && pick < 0; i++) begin
            if (slot_stamp[(first + i) % NUM_SLOTS] == 0)
               pick = (first + i) % NUM_SLOTS;
         end
         if (pick >= 0) begin
            slot_stamp[pick] = (now == 0) ? 64'd1 : now;
            if (pick + 1 > peak_mark)
               peak_mark = pick + 1;
            r.granted_slot = pick[5:0];
            r.slot_granted = 1'b1;
         end
      end else if (op == OP_END) begin
         slot_stamp[idx] = '0;
      end
      span = (peak_mark < NUM_SLOTS) ? peak_mark : NUM_SLOTS;
      for (int i = 0; i < span; i++) begin
         if (slot_stamp[i] != 0) begin
            n++;
            if (oldest == 0 || slot_stamp[i] < oldest)
               oldest = slot_stamp[i];
         end
      end
      r.busy_count = n[6:0];
      if (oldest != 0 && now > oldest)
         r.oldest_age_ms = AGE_W'((now - oldest) / 64'(NS_PER_MS));
      return r;
   endfunction

   function automatic script_row_type script_row(logic [1:0] op, logic [TS_W-1:0] ts,
                                                 logic [5:0] idx, int reps,
                                                 logic [TS_W-1:0] step, bit typed,
                                                 logic [5:0] g, logic ok, logic [6:0] busy,
                                                 logic [AGE_W-1:0] age);
      script_row_type s;
      s.op    = op;
      s.ts    = ts;
      s.idx   = idx;
      s.reps  = reps;
      s.step  = step;
      s.typed = typed;
      s.want  = '{granted_slot: g, slot_granted: ok, busy_count: busy, oldest_age_ms: age};
      return s;
   endfunction

   task automatic offer_beat(input logic [1:0] op, input logic [TS_W-1:0] ts,
                             input logic [5:0] idx, input bit typed, input slot_rsp_type want);
      slot_rsp_type predicted;
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_timestamp_ns <= ts;
      req_slot_index   <= idx;
      do @(posedge clock); while (!req_ready);
      predicted = track_beat(op, ts, idx);
      pending_rsp.push_back(typed ? want : predicted);
   endtask

   // bursts of back-to-back beats with gaps of varied length in between
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 10);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_wait();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   initial begin
      script_row_type  script [$];
      int              busy_list [$];
      logic [TS_W-1:0] ts_now;
      logic [TS_W-1:0] ts;
      logic [1:0]      op;
      logic [5:0]      idx;
      int              mix_mode;
      int              mix_left;
      int              roll;

      for (int i = 0; i < NUM_SLOTS; i++) slot_stamp[i] = '0;
      scan_hint = 0;
      peak_mark = 0;

      script.push_back(script_row(OP_QUERY, 63'd5000000, 6'd0, 1, 0, 1, 0, 0, 0, 0));
      script.push_back(script_row(OP_BEGIN, 63'd0, 6'h3F, 1, 0, 1, 0, 1, 1, 0));
      script.push_back(script_row(OP_QUERY, 63'd1000001, 6'd0, 1, 0, 1, 0, 0, 1, 1));
      script.push_back(script_row(OP_BEGIN, TS_MAX, 6'd0, 1, 0, 1, 1, 1, 2, 44'd9223372036854));
      script.push_back(script_row(OP_END, 63'd10, 6'd1, 1, 0, 1, 0, 0, 1, 0));
      // slot already free
      script.push_back(script_row(OP_END, 63'd2000000, 6'd1, 1, 0, 1, 0, 0, 1, 1));
      script.push_back(script_row(OP_END, 63'd500, 6'd63, 1, 0, 1, 0, 0, 1, 0));
      script.push_back(script_row(OP_SPARE, 63'd3000001, 6'd0, 1, 0, 1, 0, 0, 1, 3));
      script.push_back(script_row(OP_END, 63'd100, 6'd0, 1, 0, 1, 0, 0, 0, 0));
      // fill every slot, then hit the full table
      script.push_back(script_row(OP_BEGIN, 63'd1000000000, 6'd0, NUM_SLOTS, 63'd1000,
                                  0, 0, 0, 0, 0));
      script.push_back(script_row(OP_BEGIN, 63'd3000000000, 6'd0, 1, 0, 1, 0, 0, 64, 2000));
      script.push_back(script_row(OP_BEGIN, 63'd0, 6'd0, 1, 0, 1, 0, 0, 64, 0));
      script.push_back(script_row(OP_END, 63'd3000000000, 6'd37, 1, 0, 1, 0, 0, 63, 2000));
      script.push_back(script_row(OP_BEGIN, 63'd3000500000, 6'd0, 1, 0, 0, 0, 0, 0, 0));
      script.push_back(script_row(OP_QUERY, 63'h5555_5555_5555_5555, 6'h2A, 1, 0,
                                  0, 0, 0, 0, 0));
      script.push_back(script_row(OP_END, 63'd4000000000, 6'd2, 1, 0, 0, 0, 0, 0, 0));
      script.push_back(script_row(OP_BEGIN, 63'h2AAA_AAAA_AAAA_AAAA, 6'h15, 1, 0,
                                  0, 0, 0, 0, 0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (script[r]) begin
         for (int k = 0; k < script[r].reps; k++) begin
            offer_beat(script[r].op, script[r].ts + TS_W'(k) * script[r].step,
                       script[r].idx, script[r].typed, script[r].want);
            pace();
         end
      end
      drain_wait();

      ts_now   = TS_W'($urandom) << 8;
      mix_mode = MIX_BLEND;
      mix_left = 0;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (mix_left == 0) begin
            mix_mode = $urandom_range(MIX_FILL, MIX_BLEND);
            mix_left = $urandom_range(40, 150);
         end
         mix_left--;
         if (n == 300)
            want_long_hold = 1'b1;

         case ($urandom_range(0, 9))
            0:       ts_now = ts_now;
            1, 2, 3, 4: ts_now = ts_now + TS_W'($urandom_range(0, 2000000));
            5, 6, 7: ts_now = ts_now + TS_W'($urandom_range(0, 32'h3FFF_FFFF));
            8:       ts_now = ts_now + (TS_W'($urandom) << 4);
            default: ts_now = ts_now + TS_W'(NS_PER_MS);
         endcase

         roll = $urandom_range(0, 99);
         if (roll < 80)      ts = ts_now;
         else if (roll < 88) ts = TS_W'({$urandom, $urandom});
         else if (roll < 92) ts = '0;
         else if (roll < 96) ts = ts_now - TS_W'($urandom_range(0, 32'h7FFF_FFFF) % (ts_now + 1));
         else                ts = TS_MAX;

         roll = $urandom_range(0, 99);
         case (mix_mode)
            MIX_FILL:  op = (roll < 75) ? OP_BEGIN : (roll < 85) ? OP_END :
                            (roll < 95) ? OP_QUERY : OP_SPARE;
            MIX_DRAIN: op = (roll < 15) ? OP_BEGIN : (roll < 85) ? OP_END :
                            (roll < 95) ? OP_QUERY : OP_SPARE;
            default:   op = (roll < 40) ? OP_BEGIN : (roll < 75) ? OP_END :
                            (roll < 93) ? OP_QUERY : OP_SPARE;
         endcase

         busy_list.delete();
         foreach (slot_stamp[k]) if (slot_stamp[k] != 0) busy_list.push_back(k);
         if (op == OP_END && busy_list.size() != 0 && $urandom_range(0, 99) < 85)
            idx = 6'(busy_list[$urandom_range(0, busy_list.size() - 1)]);
         else
            idx = 6'($urandom_range(0, 63));

         offer_beat(op, ts, idx, 1'b0, '0);
         if (n == 500 || n == 900)
            drain_wait();
         else
            pace();
      end

      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (NUM_SLOTS + 100) @(posedge clock);
      if (mismatches == 0)
         $display("in_flight_slot_tracker_core regression: pass");
      else
         $display("in_flight_slot_tracker_core regression: fail");
      $finish;
   end

   // result side: check accepted beats, then pick the next stall pattern
   always @(posedge clock) begin
      slot_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result, nothing pending", $time);
            $display("%0t:   slot %0d granted %0d busy %0d age %0d", $time,
                     rsp_granted_slot, rsp_slot_granted, rsp_busy_count,
                     rsp_oldest_age_ms);
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_granted_slot !== want.granted_slot) begin
               $display("%0t: granted_slot expected %0d, got %0d", $time,
                        want.granted_slot, rsp_granted_slot);
               mismatches++;
            end
            if (rsp_slot_granted !== want.slot_granted) begin
               $display("%0t: slot_granted expected %0d, got %0d", $time,
                        want.slot_granted, rsp_slot_granted);
               mismatches++;
            end
            if (rsp_busy_count !== want.busy_count) begin
               $display("%0t: busy_count expected %0d, got %0d", $time,
                        want.busy_count, rsp_busy_count);
               mismatches++;
            end
            if (rsp_oldest_age_ms !== want.oldest_age_ms) begin
               $display("%0t: oldest_age_ms expected %0d, got %0d", $time,
                        want.oldest_age_ms, rsp_oldest_age_ms);
               mismatches++;
            end
         end
      end

      if (rx_left == 0) begin
         rx_mode <= $urandom_range(RX_OPEN, RX_PERIODIC);
         rx_left <= $urandom_range(100, 1500);
      end else begin
         rx_left <= rx_left - 1;
      end

      if (want_long_hold && !long_hold_done) begin
         // long hold-off so the tracker backs up and stalls its input
         rsp_ready  <= 1'b0;
         hold_count <= hold_count + 1;
         if (hold_count == LONG_HOLD - 1)
            long_hold_done <= 1'b1;
      end else begin
         case (rx_mode)
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_RANDOM: rsp_ready <= ($urandom_range(0, 99) < 60);
            default:   rsp_ready <= (rx_left % 7) > 2;
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("in_flight_slot_tracker_core regression: fail");
         $finish;
      end
   end

endmodule
